>>> rtl/core/fdp_pkg.sv
// Shared constants, codes and types of the frame descriptor pool.
package fdp_pkg;

  localparam int unsigned SLOT_COUNT   = 64;
  localparam int unsigned BUFFER_BYTES = 2097152;

  localparam int unsigned SlotW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SizeW = 22;
  localparam int unsigned OffW  = 21;
  localparam int unsigned TagW  = 4;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StsW  = 3;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned HeldW = 8;

  // Command codes; any code with the reset bit set clears the pool.
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd0;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd1;
  localparam int unsigned     CMD_RESET_BIT = 1;

  localparam logic [StsW-1:0] STS_WRITTEN     = 3'd0;
  localparam logic [StsW-1:0] STS_DROPPED     = 3'd1;
  localparam logic [StsW-1:0] STS_ZERO_SIZE   = 3'd2;
  localparam logic [StsW-1:0] STS_READ_OK     = 3'd3;
  localparam logic [StsW-1:0] STS_EMPTY_RESET = 3'd4;
  localparam logic [StsW-1:0] STS_SLOT_ERROR  = 3'd5;
  localparam logic [StsW-1:0] STS_RESET       = 3'd6;

  localparam logic [RegIdxW-1:0] REG_AUDIO_LIMIT = 2'd0;
  localparam logic [RegIdxW-1:0] REG_VIDEO_LIMIT = 2'd1;
  localparam logic [RegIdxW-1:0] REG_FRAME_CAP   = 2'd2;

  localparam logic [SizeW-1:0] AUDIO_LIMIT_RST = 22'd262144;
  localparam logic [SizeW-1:0] VIDEO_LIMIT_RST = 22'd2097152;
  localparam logic [SizeW-1:0] FRAME_CAP_RST   = 22'd190000;

  typedef struct packed {
    logic [OffW-1:0]  offset;
    logic [SizeW-1:0] size;
    logic             key;
    logic [TagW-1:0]  enc;
    logic [TagW-1:0]  kind;
  } desc_t;

  localparam int unsigned DescW = $bits(desc_t);

  // Datapath limits; audio and video already clamped to the buffer size.
  typedef struct packed {
    logic [SizeW-1:0] audio_limit;
    logic [SizeW-1:0] video_limit;
    logic [SizeW-1:0] frame_cap;
  } cfg_t;

endpackage

>>> rtl/core/fdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fdp_cfg.sv
// Configuration registers of the frame descriptor pool, with limit clamping.
module fdp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdp_pkg::RegIdxW-1:0]    cfg_idx_i,
  input  logic [fdp_pkg::SizeW-1:0]      cfg_wdata_i,
  output fdp_pkg::cfg_t                  cfg_o
);
  import fdp_pkg::*;

  logic [SizeW-1:0] audio_q, video_q, cap_q;

  function automatic logic [SizeW-1:0] clamp_limit(logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    if (32'(v) > 32'(BUFFER_BYTES)) begin
      r = SizeW'(BUFFER_BYTES);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_q <= AUDIO_LIMIT_RST;
      video_q <= VIDEO_LIMIT_RST;
      cap_q   <= FRAME_CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AUDIO_LIMIT: audio_q <= cfg_wdata_i;
        REG_VIDEO_LIMIT: video_q <= cfg_wdata_i;
        REG_FRAME_CAP:   cap_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.audio_limit = clamp_limit(audio_q);
  assign cfg_o.video_limit = clamp_limit(video_q);
  assign cfg_o.frame_cap   = cap_q;

endmodule

>>> rtl/core/frame_descriptor_pool_core.sv
// Top level of the frame descriptor pool: ring pointers, counters and descriptor RAM.
//
// Usage:
//   Requests enter on the in channel (valid/ready): a command (write, read
//   oldest, reset pool) plus the frame fields used by a write. Each request
//   yields exactly one result on the out channel (valid/ready): a status,
//   the payload offset, the fields of a frame read, the lost flag and the
//   number of frames held after the request.
//   The descriptor RAM is read at the read slot on the accepting edge;
//   the evaluate step then updates the pointers, writes the RAM and loads
//   the result register. A new request is taken only after the previous
//   one leaves the evaluate step, as the RAM read-modify-write must finish;
//   the next request is accepted while a result still waits in the output
//   register. When the receiver stalls, the finished request holds in the
//   evaluate step until the output register frees up; the input side stops
//   meanwhile. Reset clears pointers, counters, the lost flag and every
//   descriptor valid bit at once, so the RAM needs no clearing pass.
//   Configuration writes take effect at once; the user must make them
//   while idle, as the block itself does not enforce this.
module frame_descriptor_pool_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fdp_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [fdp_pkg::SizeW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fdp_pkg::CmdW-1:0]        command_i,
  input  logic                            pool_kind_i,
  input  logic [fdp_pkg::SizeW-1:0]       frame_size_i,
  input  logic                            key_frame_i,
  input  logic [fdp_pkg::TagW-1:0]        encoding_i,
  input  logic [fdp_pkg::TagW-1:0]        stream_kind_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fdp_pkg::StsW-1:0]        status_o,
  output logic [fdp_pkg::OffW-1:0]        data_offset_o,
  output logic [fdp_pkg::SizeW-1:0]       size_out_o,
  output logic                            key_frame_out_o,
  output logic [fdp_pkg::TagW-1:0]        encoding_out_o,
  output logic [fdp_pkg::TagW-1:0]        stream_kind_out_o,
  output logic                            lost_flag_o,
  output logic [fdp_pkg::HeldW-1:0]       frames_held_o
);
  import fdp_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  cfg_t cfg;

  fdp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Control state
  logic             state_q, state_d;
  logic [SlotW-1:0] wr_slot_q, wr_slot_d;
  logic [SlotW-1:0] rd_slot_q, rd_slot_d;
  logic [SizeW-1:0] fill_q, fill_d;
  logic [SizeW-1:0] held_bytes_q, held_bytes_d;
  logic [CntW-1:0]  held_frames_q, held_frames_d;
  logic             dropped_q, dropped_d;
  logic [SLOT_COUNT-1:0] vld_q, vld_d;
  logic             rd_vld_q;
  logic             out_valid_q, out_valid_d;

  // Latched request
  logic [CmdW-1:0]  cmd_q;
  logic             kind_sel_q;
  logic [SizeW-1:0] size_q;
  logic             key_q;
  logic [TagW-1:0]  enc_q, tag_q;

  // Result register
  logic [StsW-1:0]  sts_q, sts_d;
  logic [OffW-1:0]  off_q, off_d;
  desc_t            rdesc_q, rdesc_d;

  logic             in_acc, commit, out_free;
  logic             ram_we;
  logic [SlotW-1:0] ram_waddr;
  desc_t            ram_wdata, ram_rdata, rd_desc;
  logic [SizeW-1:0] limit;
  logic [SizeW:0]   fill_sum, held_sum;
  logic             drop, empty;

  function automatic logic [SlotW-1:0] next_slot(logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(SLOT_COUNT - 1)) begin
      r = '0;
    end else begin
      r = s + SlotW'(1);
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == S_EXEC) && out_free;

  fdp_ram #(
    .Width(DescW),
    .Depth(SLOT_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i(rd_slot_q),
    .rdata_o(ram_rdata)
  );

  // An entry never written since reset reads as cleared.
  assign rd_desc  = rd_vld_q ? ram_rdata : '0;

  assign limit    = kind_sel_q ? cfg.video_limit : cfg.audio_limit;
  assign fill_sum = {1'b0, fill_q} + {1'b0, size_q};
  assign held_sum = {1'b0, held_bytes_q} + {1'b0, size_q};
  assign drop     = (fill_sum > {1'b0, limit}) || (held_sum > {1'b0, limit}) ||
                    (size_q > cfg.frame_cap) || (held_frames_q >= CntW'(SLOT_COUNT));
  assign empty    = (held_bytes_q == '0) || (held_frames_q == '0);

  always_comb begin
    state_d       = state_q;
    wr_slot_d     = wr_slot_q;
    rd_slot_d     = rd_slot_q;
    fill_d        = fill_q;
    held_bytes_d  = held_bytes_q;
    held_frames_d = held_frames_q;
    dropped_d     = dropped_q;
    vld_d         = vld_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    sts_d         = sts_q;
    off_d         = off_q;
    rdesc_d       = rdesc_q;
    ram_we        = 1'b0;
    ram_waddr     = wr_slot_q;
    ram_wdata     = '0;

    if (in_acc) begin
      state_d = S_EXEC;
    end

    if (commit) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      off_d       = '0;
      rdesc_d     = '0;
      priority if (cmd_q[CMD_RESET_BIT]) begin
        wr_slot_d     = '0;
        rd_slot_d     = '0;
        fill_d        = '0;
        held_bytes_d  = '0;
        held_frames_d = '0;
        dropped_d     = 1'b0;
        sts_d         = STS_RESET;
      end else if (cmd_q == CMD_WRITE) begin
        if (size_q == '0) begin
          sts_d = STS_ZERO_SIZE;
        end else if (drop) begin
          dropped_d = 1'b1;
          sts_d     = STS_DROPPED;
        end else begin
          ram_we           = 1'b1;
          ram_waddr        = wr_slot_q;
          ram_wdata.offset = fill_q[OffW-1:0];
          ram_wdata.size   = size_q;
          ram_wdata.key    = key_q;
          ram_wdata.enc    = enc_q;
          ram_wdata.kind   = tag_q;
          vld_d[wr_slot_q] = 1'b1;
          dropped_d        = 1'b0;
          off_d            = fill_q[OffW-1:0];
          fill_d           = fill_sum[SizeW-1:0];
          held_bytes_d     = held_sum[SizeW-1:0];
          held_frames_d    = held_frames_q + CntW'(1);
          wr_slot_d        = next_slot(wr_slot_q);
          sts_d            = STS_WRITTEN;
        end
      end else begin
        if (empty) begin
          wr_slot_d     = '0;
          rd_slot_d     = '0;
          fill_d        = '0;
          held_bytes_d  = '0;
          held_frames_d = '0;
          sts_d         = STS_EMPTY_RESET;
        end else if (rd_desc.size == '0) begin
          sts_d = STS_SLOT_ERROR;
        end else begin
          // Pop the oldest entry and clear its slot.
          off_d            = rd_desc.offset;
          rdesc_d          = rd_desc;
          rdesc_d.offset   = '0;
          ram_we           = 1'b1;
          ram_waddr        = rd_slot_q;
          ram_wdata        = '0;
          vld_d[rd_slot_q] = 1'b0;
          held_frames_d    = held_frames_q - CntW'(1);
          held_bytes_d     = (held_bytes_q >= rd_desc.size) ?
                             held_bytes_q - rd_desc.size : '0;
          rd_slot_d        = next_slot(rd_slot_q);
          sts_d            = STS_READ_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      wr_slot_q     <= '0;
      rd_slot_q     <= '0;
      fill_q        <= '0;
      held_bytes_q  <= '0;
      held_frames_q <= '0;
      dropped_q     <= 1'b0;
      vld_q         <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      wr_slot_q     <= wr_slot_d;
      rd_slot_q     <= rd_slot_d;
      fill_q        <= fill_d;
      held_bytes_q  <= held_bytes_d;
      held_frames_q <= held_frames_d;
      dropped_q     <= dropped_d;
      vld_q         <= vld_d;
      out_valid_q   <= out_valid_d;
      if (in_acc) begin
        rd_vld_q <= vld_q[rd_slot_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q      <= command_i;
      kind_sel_q <= pool_kind_i;
      size_q     <= frame_size_i;
      key_q      <= key_frame_i;
      enc_q      <= encoding_i;
      tag_q      <= stream_kind_i;
    end
    sts_q   <= sts_d;
    off_q   <= off_d;
    rdesc_q <= rdesc_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = sts_q;
  assign data_offset_o     = off_q;
  assign size_out_o        = rdesc_q.size;
  assign key_frame_out_o   = rdesc_q.key;
  assign encoding_out_o    = rdesc_q.enc;
  assign stream_kind_out_o = rdesc_q.kind;
  assign lost_flag_o       = dropped_q;
  assign frames_held_o     = (32'(held_frames_q) > 32'(255)) ? 8'hFF : HeldW'(held_frames_q);

endmodule

>>> sim/fdp_pool_check_pkg.sv
// Scoreboard for the frame descriptor pool: ring predictor and result checker.
`timescale 1ns / 1ps
package fdp_pool_check_pkg;
  import fdp_pkg::*;

  typedef struct packed {
    logic [StsW-1:0]  status;
    logic [OffW-1:0]  offset;
    logic [SizeW-1:0] size;
    logic             key;
    logic [TagW-1:0]  enc;
    logic [TagW-1:0]  skind;
    logic             lost;
    logic [HeldW-1:0] held;
  } pool_result_t;

  localparam int unsigned MaxReports = 10;

  class pool_predictor;
    int unsigned audio_limit;
    int unsigned video_limit;
    int unsigned frame_cap;
    int unsigned wr_slot;
    int unsigned rd_slot;
    int unsigned fill_offset;
    int unsigned held_bytes;
    int unsigned held_frames;
    bit          lost;
    desc_t       ring [SLOT_COUNT];
    pool_result_t due_results [$];
    int unsigned errors;
    int unsigned requests;
    int unsigned ring_full_drops;
    int unsigned status_seen [8];

    function new();
      audio_limit = AUDIO_LIMIT_RST;
      video_limit = VIDEO_LIMIT_RST;
      frame_cap   = FRAME_CAP_RST;
      clear_pointers();
      lost = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      errors = 0;
      requests = 0;
      ring_full_drops = 0;
    endfunction

    function void clear_pointers();
      wr_slot = 0;
      rd_slot = 0;
      fill_offset = 0;
      held_bytes = 0;
      held_frames = 0;
    endfunction

    function void set_register(logic [RegIdxW-1:0] idx, logic [SizeW-1:0] value);
      case (idx)
        REG_AUDIO_LIMIT: audio_limit = value;
        REG_VIDEO_LIMIT: video_limit = value;
        REG_FRAME_CAP:   frame_cap = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Advance the ring for one accepted request and queue the result it must give.
    function void take_request(logic [CmdW-1:0] cmd, logic kind_sel, logic [SizeW-1:0] size_in,
                               logic key, logic [TagW-1:0] enc, logic [TagW-1:0] skind);
      pool_result_t r;
      int unsigned  lim;
      int unsigned  sz;
      desc_t        d;
      r = '0;
      sz = size_in;
      requests++;
      if (cmd[CMD_RESET_BIT]) begin
        clear_pointers();
        lost = 1'b0;
        r.status = STS_RESET;
      end else if (cmd == CMD_WRITE) begin
        lim = kind_sel ? video_limit : audio_limit;
        if (lim > BUFFER_BYTES) lim = BUFFER_BYTES;
        if (sz == 0) begin
          r.status = STS_ZERO_SIZE;
        end else if (fill_offset + sz > lim || held_bytes + sz > lim || sz > frame_cap ||
                     held_frames >= SLOT_COUNT) begin
          if (held_frames >= SLOT_COUNT) ring_full_drops++;
          lost = 1'b1;
          r.status = STS_DROPPED;
        end else begin
          d.offset = OffW'(fill_offset);
          d.size = size_in;
          d.key = key;
          d.enc = enc;
          d.kind = skind;
          ring[wr_slot] = d;
          lost = 1'b0;
          r.offset = OffW'(fill_offset);
          fill_offset += sz;
          held_bytes += sz;
          held_frames++;
          wr_slot = (wr_slot + 1 >= SLOT_COUNT) ? 0 : wr_slot + 1;
          r.status = STS_WRITTEN;
        end
      end else begin
        if (held_bytes == 0 || held_frames == 0) begin
          clear_pointers();
          r.status = STS_EMPTY_RESET;
        end else begin
          d = ring[rd_slot];
          if (d.size == '0) begin
            r.status = STS_SLOT_ERROR;
          end else begin
            r.offset = d.offset;
            r.size = d.size;
            r.key = d.key;
            r.enc = d.enc;
            r.skind = d.kind;
            held_frames--;
            held_bytes = (held_bytes >= d.size) ? held_bytes - d.size : 0;
            ring[rd_slot] = '0;
            rd_slot = (rd_slot + 1 >= SLOT_COUNT) ? 0 : rd_slot + 1;
            r.status = STS_READ_OK;
          end
        end
      end
      r.lost = lost;
      r.held = (held_frames > 255) ? HeldW'(255) : HeldW'(held_frames);
      status_seen[r.status]++;
      due_results.push_back(r);
    endfunction

    function string describe(pool_result_t r);
      return $sformatf("sts=%0d off=%0d size=%0d key=%0d enc=%0d kind=%0d lost=%0d held=%0d",
                       r.status, r.offset, r.size, r.key, r.enc, r.skind, r.lost, r.held);
    endfunction

    function void check_result(pool_result_t act);
      pool_result_t exp_r;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("mismatch %0d: result with no request pending: %s", errors, describe(act));
        return;
      end
      exp_r = due_results.pop_front();
      if (act.status !== exp_r.status || act.offset !== exp_r.offset ||
          act.size !== exp_r.size || act.key !== exp_r.key || act.enc !== exp_r.enc ||
          act.skind !== exp_r.skind || act.lost !== exp_r.lost || act.held !== exp_r.held) begin
        errors++;
        if (errors <= MaxReports)
          $display("mismatch %0d: expected %s, got %s", errors, describe(exp_r), describe(act));
      end
    endfunction
  endclass

endpackage

>>> sim/tb_frame_descriptor_pool_core.sv
// Testbench top: drives requests and configuration into the descriptor pool and checks results.
`timescale 1ns / 1ps
module tb_frame_descriptor_pool_core;
  import fdp_pkg::*;
  import fdp_pool_check_pkg::*;

  localparam int unsigned HalfPeriodNs   = 4;
  localparam int unsigned ResetCycles    = 12;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned HoldOffCycles  = 400;
  localparam int unsigned PhaseItems     = 250;
  localparam int unsigned PhaseCount     = 8;
  localparam int unsigned TimeoutNs      = 4000000;

  localparam logic [CmdW-1:0]  CMD_RESET     = 2'd2;
  localparam logic [CmdW-1:0]  CMD_RESET_ALT = 2'd3;
  localparam logic [SizeW-1:0] SIZE_ALL_ONES = 22'h3FFFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RegIdxW-1:0]  cfg_idx_i;
  logic [SizeW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i;
  logic                pool_kind_i;
  logic [SizeW-1:0]    frame_size_i;
  logic                key_frame_i;
  logic [TagW-1:0]     encoding_i;
  logic [TagW-1:0]     stream_kind_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [StsW-1:0]     status_o;
  logic [OffW-1:0]     data_offset_o;
  logic [SizeW-1:0]    size_out_o;
  logic                key_frame_out_o;
  logic [TagW-1:0]     encoding_out_o;
  logic [TagW-1:0]     stream_kind_out_o;
  logic                lost_flag_o;
  logic [HeldW-1:0]    frames_held_o;

  pool_predictor ring_pred;
  int unsigned   send_gap_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   hold_off_asked = 0;
  logic [SizeW-1:0] cur_cap = FRAME_CAP_RST;

  frame_descriptor_pool_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .pool_kind_i       (pool_kind_i),
    .frame_size_i      (frame_size_i),
    .key_frame_i       (key_frame_i),
    .encoding_i        (encoding_i),
    .stream_kind_i     (stream_kind_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .data_offset_o     (data_offset_o),
    .size_out_o        (size_out_o),
    .key_frame_out_o   (key_frame_out_o),
    .encoding_out_o    (encoding_out_o),
    .stream_kind_out_o (stream_kind_out_o),
    .lost_flag_o       (lost_flag_o),
    .frames_held_o     (frames_held_o)
  );

  always #(HalfPeriodNs) clk_i = ~clk_i;

  task automatic send_request(logic [CmdW-1:0] cmd, logic kind_sel, logic [SizeW-1:0] size_in,
                              logic key, logic [TagW-1:0] enc, logic [TagW-1:0] skind);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    pool_kind_i   <= kind_sel;
    frame_size_i  <= size_in;
    key_frame_i   <= key;
    encoding_i    <= enc;
    stream_kind_i <= skind;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    ring_pred.take_request(cmd, kind_sel, size_in, key, enc, skind);
  endtask

  task automatic random_request(int unsigned write_pct, int unsigned read_pct);
    int unsigned      roll;
    int unsigned      size_roll;
    logic [CmdW-1:0]  cmd;
    logic [SizeW-1:0] sz;
    roll = $urandom_range(0, 99);
    size_roll = $urandom_range(0, 99);
    if (roll < write_pct) cmd = CMD_WRITE;
    else if (roll < write_pct + read_pct) cmd = CMD_READ;
    else cmd = $urandom_range(0, 1) ? CMD_RESET : CMD_RESET_ALT;
    // mostly small frames so the ring fills; some near the cap and some wild
    if (size_roll < 6) sz = '0;
    else if (size_roll < 70) sz = SizeW'($urandom_range(1, 4096));
    else if (size_roll < 85) sz = SizeW'($urandom_range(4097, 65536));
    else if (size_roll < 93) sz = SizeW'($urandom_range(65537, 262144));
    else if (size_roll < 97) sz = cur_cap + SizeW'($urandom_range(0, 2)) - 1'b1;
    else sz = SizeW'($urandom());
    send_request(cmd, 1'($urandom()), sz, 1'($urandom()), TagW'($urandom()),
                 TagW'($urandom()));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (ring_pred.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [SizeW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ring_pred.set_register(idx, value);
    if (idx == REG_FRAME_CAP) cur_cap = value;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [SizeW-1:0] audio, logic [SizeW-1:0] video,
                           logic [SizeW-1:0] cap, int unsigned write_pct,
                           int unsigned read_pct, int unsigned gap, int unsigned stall,
                           bit hold);
    wait_idle();
    write_reg(REG_AUDIO_LIMIT, audio);
    write_reg(REG_VIDEO_LIMIT, video);
    write_reg(REG_FRAME_CAP, cap);
    send_gap_pct = gap;
    stall_pct = stall;
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      // keep offering requests while the output side is held off
      if (hold && i == 20) hold_off_asked++;
      random_request(write_pct, read_pct);
    end
  endtask

  // Receiver: check each accepted result, then pick ready for the next cycle.
  initial begin
    pool_result_t act;
    int unsigned  hold_off_seen;
    int unsigned  stall_left;
    hold_off_seen = 0;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        act.status = status_o;
        act.offset = data_offset_o;
        act.size   = size_out_o;
        act.key    = key_frame_out_o;
        act.enc    = encoding_out_o;
        act.skind  = stream_kind_out_o;
        act.lost   = lost_flag_o;
        act.held   = frames_held_o;
        ring_pred.check_result(act);
      end
      if (hold_off_asked != hold_off_seen) begin
        hold_off_seen = hold_off_asked;
        stall_left = HoldOffCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("tb_frame_descriptor_pool_core: errors");
    $finish;
  end

  initial begin
    ring_pred = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    command_i     <= CMD_WRITE;
    pool_kind_i   <= 1'b0;
    frame_size_i  <= '0;
    key_frame_i   <= 1'b0;
    encoding_i    <= '0;
    stream_kind_i <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset limits.
    send_request(CMD_READ, 1'b0, 22'd0, 1'b0, 4'd0, 4'd0);          // read on empty pool
    send_request(CMD_WRITE, 1'b1, 22'd0, 1'b1, 4'd3, 4'd3);         // zero size
    send_request(CMD_WRITE, 1'b1, 22'd1, 1'b1, 4'd15, 4'd15);
    send_request(CMD_WRITE, 1'b0, 22'd190000, 1'b0, 4'd0, 4'd0);    // exactly at the cap
    send_request(CMD_WRITE, 1'b0, 22'd190001, 1'b1, 4'd1, 4'd2);    // over the cap
    send_request(CMD_WRITE, 1'b0, 22'd72144, 1'b0, 4'd2, 4'd1);     // one past audio limit
    send_request(CMD_WRITE, 1'b0, 22'd72143, 1'b1, 4'd9, 4'd6);     // fills audio limit
    send_request(CMD_WRITE, 1'b0, 22'd1, 1'b0, 4'd4, 4'd4);
    send_request(CMD_WRITE, 1'b1, SIZE_ALL_ONES, 1'b1, 4'd15, 4'd0);
    send_request(CMD_READ, 1'b0, 22'd0, 1'b0, 4'd0, 4'd0);
    send_request(CMD_READ, 1'b1, SIZE_ALL_ONES, 1'b1, 4'd15, 4'd15);
    send_request(CMD_READ, 1'b0, 22'd0, 1'b0, 4'd0, 4'd0);
    send_request(CMD_READ, 1'b0, 22'd0, 1'b0, 4'd0, 4'd0);          // drained: empty reset
    send_request(CMD_RESET, 1'b0, 22'd0, 1'b0, 4'd0, 4'd0);
    send_request(CMD_WRITE, 1'b1, 22'd5, 1'b1, 4'd10, 4'd5);
    send_request(CMD_RESET_ALT, 1'b1, 22'd9, 1'b1, 4'd7, 4'd7);     // old slot left behind
    send_request(CMD_READ, 1'b0, 22'd0, 1'b0, 4'd0, 4'd0);
    send_request(CMD_WRITE, 1'b0, 22'd7, 1'b0, 4'd12, 4'd8);
    send_request(CMD_READ, 1'b0, 22'd0, 1'b0, 4'd0, 4'd0);

    run_phase(AUDIO_LIMIT_RST, VIDEO_LIMIT_RST, FRAME_CAP_RST, 55, 42, 0, 0, 1'b0);
    run_phase(22'd0, 22'd2097152, 22'd2097152, 70, 28, 80, 0, 1'b0);
    run_phase(SIZE_ALL_ONES, 22'd4096, 22'd4096, 50, 47, 0, 80, 1'b0);
    run_phase(22'd2097152, 22'd2097152, 22'd0, 40, 57, 8, 8, 1'b0);
    run_phase(22'd1024, SIZE_ALL_ONES, 22'd3000, 80, 18, 0, 0, 1'b1);
    run_phase(SizeW'($urandom()), SizeW'($urandom()), SizeW'($urandom()), 60, 37, 80, 0, 1'b0);
    run_phase(AUDIO_LIMIT_RST, VIDEO_LIMIT_RST, FRAME_CAP_RST, 50, 45, 0, 80, 1'b0);
    run_phase(22'd65536, 22'd131072, 22'd65536, 65, 32, 8, 8, 1'b0);
    wait_idle();

    $display("covered %0d requests in %0d setting phases plus a %0d-cycle output hold-off",
             ring_pred.requests, PhaseCount, HoldOffCycles);
    $display("outcomes: %0d written, %0d dropped (%0d on a full ring), %0d zero size, %0d read, %0d empty-pool reads, %0d resets",
             ring_pred.status_seen[STS_WRITTEN], ring_pred.status_seen[STS_DROPPED],
             ring_pred.ring_full_drops, ring_pred.status_seen[STS_ZERO_SIZE],
             ring_pred.status_seen[STS_READ_OK], ring_pred.status_seen[STS_EMPTY_RESET],
             ring_pred.status_seen[STS_RESET]);
    if (ring_pred.errors == 0 && ring_pred.pending() == 0) begin
      $display("tb_frame_descriptor_pool_core: clean");
    end else begin
      $display("tb_frame_descriptor_pool_core: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/fdp_pkg.sv
rtl/core/fdp_ram.sv
rtl/core/fdp_cfg.sv
rtl/core/frame_descriptor_pool_core.sv
sim/fdp_pool_check_pkg.sv
sim/tb_frame_descriptor_pool_core.sv
